// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/chbd_pkg.sv
// types, constants and helpers of the chunked body decoder
package chbd_pkg;

  localparam int MAX_LINE_DEFAULT  = 4096;
  localparam int SIZE_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS         = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_ADDR_BITS = 2;
  localparam int APB_DATA_BITS = 32;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_CHUNKED_MODE = 2'd0;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_AFTER   = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    HEX_SKIP_WS = 2'd0,
    HEX_DIGITS  = 2'd1,
    HEX_IGNORE  = 2'd2
  } hex_stage_t;

  typedef enum logic [1:0] {
    STATUS_RUNNING  = 2'd0,
    STATUS_FINISHED = 2'd1,
    STATUS_ERROR    = 2'd2
  } status_t;

  typedef struct packed {
    logic       closed;
    logic       is_lf;
    logic       is_cr;
    logic       is_ws;
    logic       is_hex;
    logic [3:0] digit;
    logic [7:0] data;
  } token_t;

  function automatic status_t status_of(phase_t ph);
    status_t s;
    case (ph)
      PH_DONE:  s = STATUS_FINISHED;
      PH_ERROR: s = STATUS_ERROR;
      default:  s = STATUS_RUNNING;
    endcase
    return s;
  endfunction

endpackage

// File: design/chbd_front.sv
// front end: classifies each incoming byte into a token
module chbd_front (
  input  logic [7:0]      byte_value,
  input  logic            closed,
  output chbd_pkg::token_t token
);
  import chbd_pkg::*;

  always_comb begin
    token.closed = closed;
    token.data   = byte_value;
    token.is_lf  = (byte_value == CHAR_LF);
    token.is_cr  = (byte_value == CHAR_CR);
    token.is_ws  = (byte_value == CHAR_SPACE) || (byte_value == CHAR_TAB) ||
                   (byte_value == CHAR_VT) || (byte_value == CHAR_FF);
    token.is_hex = 1'b0;
    token.digit  = 4'd0;
    if (byte_value >= 8'h30 && byte_value <= 8'h39) begin
      token.is_hex = 1'b1;
      token.digit  = 4'(byte_value - 8'h30);
    end else if (byte_value >= 8'h61 && byte_value <= 8'h66) begin
      token.is_hex = 1'b1;
      token.digit  = 4'(byte_value - 8'h57);
    end else if (byte_value >= 8'h41 && byte_value <= 8'h46) begin
      token.is_hex = 1'b1;
      token.digit  = 4'(byte_value - 8'h37);
    end
  end

endmodule

// File: design/chbd_queue.sv
// short token queue between front and back
module chbd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  chbd_pkg::token_t push_token,
  input  logic             pop,
  output chbd_pkg::token_t head,
  output logic             nonempty,
  output logic             full
);
  import chbd_pkg::*;

  token_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign head     = slots[rd_ptr];
  assign nonempty = (count != '0);
  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/chbd_back.sv
// back end: framing state machine and output register
module chbd_back #(
  parameter int MAX_LINE  = chbd_pkg::MAX_LINE_DEFAULT,
  parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             chunked_mode,
  input  chbd_pkg::token_t tok,
  input  logic             tok_valid,
  output logic             tok_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             body_valid,
  output logic [7:0]       body_byte,
  output logic [1:0]       status
);
  import chbd_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_LINE + 2);

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  chunk_left, chunk_left_next;
  logic [SIZE_BITS-1:0]  size_accum, size_accum_next;
  logic [LEN_BITS-1:0]   line_length, line_length_next;
  hex_stage_t            hex_stage, hex_stage_next;
  logic                  line_nonempty, line_nonempty_next;

  logic body_valid_next;
  logic running;
  logic last_byte;
  logic line_full;
  logic accum_zero;
  logic accum_sat;

  assign tok_pop    = tok_valid && (!out_valid || !out_stall);
  assign running    = (phase != PH_DONE) && (phase != PH_ERROR);
  assign last_byte  = (chunk_left[SIZE_BITS-1:1] == '0);
  assign line_full  = (line_length >= LEN_BITS'(MAX_LINE));
  assign accum_zero = (size_accum == '0);
  assign accum_sat  = (size_accum[SIZE_BITS-1 -: 4] != 4'd0);

  // next phase
  always_comb begin
    phase_next = phase;
    if (tok_pop && running) begin
      if (tok.closed) begin
        phase_next = (chunked_mode && phase == PH_AFTER) ? PH_ERROR : PH_DONE;
      end else if (chunked_mode) begin
        case (phase)
          PH_DATA: begin
            if (last_byte) begin
              phase_next = PH_AFTER;
            end
          end
          PH_SIZE: begin
            if (tok.is_lf) begin
              if (line_nonempty) begin
                phase_next = accum_zero ? PH_TRAILER : PH_DATA;
              end
            end else if (!tok.is_cr && line_full) begin
              phase_next = PH_ERROR;
            end
          end
          PH_AFTER: begin
            if (tok.is_lf) begin
              phase_next = PH_SIZE;
            end else if (!tok.is_cr && line_full) begin
              phase_next = PH_ERROR;
            end
          end
          PH_TRAILER: begin
            if (tok.is_lf) begin
              if (!line_nonempty) begin
                phase_next = PH_DONE;
              end
            end else if (!tok.is_cr && line_full) begin
              phase_next = PH_DONE;
            end
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // line and chunk registers, result
  always_comb begin
    chunk_left_next    = chunk_left;
    size_accum_next    = size_accum;
    line_length_next   = line_length;
    hex_stage_next     = hex_stage;
    line_nonempty_next = line_nonempty;
    body_valid_next    = 1'b0;
    if (tok_pop && running && !tok.closed) begin
      if (!chunked_mode) begin
        body_valid_next = 1'b1;
      end else if (phase == PH_DATA) begin
        body_valid_next = 1'b1;
        if (chunk_left != '0) begin
          chunk_left_next = chunk_left - 1'b1;
        end
        if (last_byte) begin
          size_accum_next    = '0;
          line_length_next   = '0;
          hex_stage_next     = HEX_SKIP_WS;
          line_nonempty_next = 1'b0;
        end
      end else if (tok.is_lf) begin
        if (phase == PH_SIZE && line_nonempty && !accum_zero) begin
          chunk_left_next = size_accum;
        end
        size_accum_next    = '0;
        line_length_next   = '0;
        hex_stage_next     = HEX_SKIP_WS;
        line_nonempty_next = 1'b0;
      end else if (!tok.is_cr) begin
        if (phase == PH_SIZE && !(hex_stage == HEX_SKIP_WS && tok.is_ws) &&
            hex_stage != HEX_IGNORE) begin
          if (!tok.is_hex) begin
            hex_stage_next = HEX_IGNORE;
          end else begin
            hex_stage_next  = HEX_DIGITS;
            size_accum_next = accum_sat ? '1 : {size_accum[SIZE_BITS-5:0], tok.digit};
          end
        end
        line_nonempty_next = 1'b1;
        line_length_next   = line_length + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      chunk_left    <= '0;
      size_accum    <= '0;
      line_length   <= '0;
      hex_stage     <= HEX_SKIP_WS;
      line_nonempty <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      chunk_left    <= chunk_left_next;
      size_accum    <= size_accum_next;
      line_length   <= line_length_next;
      hex_stage     <= hex_stage_next;
      line_nonempty <= line_nonempty_next;
      if (tok_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      body_valid <= body_valid_next;
      body_byte  <= body_valid_next ? tok.data : 8'd0;
      status     <= status_of(phase_next);
    end
  end

endmodule

// File: design/http_chunked_body_decoder.sv
// top level of the chunked body decoder with its register port
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid in_stall byte_value closed  | into block
//   out     | out_valid out_stall body_valid       | out of block
//           | body_byte status                     |
//   apb     | psel penable pwrite paddr pwdata     | register port
//           | prdata pready                        |
//
// one byte per cycle while not stalled; bytes go through queue and output register
// a four-entry token queue decouples byte intake from the framing state machine
// in_stall rises only when that queue is full, out_stall holds the output register
// reset is synchronous and clears the queue, the framing state and the mode register
module http_chunked_body_decoder #(
  parameter int MAX_LINE  = chbd_pkg::MAX_LINE_DEFAULT,
  parameter int SIZE_BITS = chbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         byte_value,
  input  logic                               closed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               body_valid,
  output logic [7:0]                         body_byte,
  output logic [1:0]                         status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [chbd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [chbd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [chbd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import chbd_pkg::*;

  logic   chunked_mode;
  token_t front_token;
  token_t head_token;
  logic   q_nonempty;
  logic   q_full;
  logic   q_pop;
  logic   q_push;

  assign pready   = 1'b1;
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CHUNKED_MODE) begin
      chunked_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_CHUNKED_MODE) begin
      prdata[0] = chunked_mode;
    end
  end

  chbd_front u_front (
    .byte_value (byte_value),
    .closed     (closed),
    .token      (front_token)
  );

  chbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_token (front_token),
    .pop        (q_pop),
    .head       (head_token),
    .nonempty   (q_nonempty),
    .full       (q_full)
  );

  chbd_back #(
    .MAX_LINE  (MAX_LINE),
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .chunked_mode (chunked_mode),
    .tok          (head_token),
    .tok_valid    (q_nonempty),
    .tok_pop      (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .body_valid   (body_valid),
    .body_byte    (body_byte),
    .status       (status)
  );

endmodule

// File: design/chbd_checker.sv
// port-level checks of the chunked body decoder and their bind
`include "assert_macros.svh"

module chbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       body_valid,
  input logic [7:0] body_byte,
  input logic [1:0] status
);
  import chbd_pkg::*;

  `CHK_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !out_valid, "output valid after reset")
  `CHK_ASSERT(a_valid_holds, clk, rst, out_valid && out_stall |=> out_valid, "result dropped")
  `CHK_ASSERT(a_payload_only_running, clk, rst, out_valid && body_valid |-> status == STATUS_RUNNING, "payload byte after end")
  `CHK_ASSERT(a_idle_byte_zero, clk, rst, out_valid && !body_valid |-> body_byte == 8'd0, "stray byte without payload")

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (.*);
